// ===== rtl/flp_pkg.sv =====
// ----------------------------------------------------------------------------
// flp_pkg: shared types and constants of the flow lookup and cell segmenter
// Transaction payloads, operation codes and the command and status groups
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package flp_pkg;

    localparam logic [1:0] OP_RULE_WR = 2'd0;
    localparam logic [1:0] OP_FLOW_WR = 2'd1;
    localparam logic [1:0] OP_PACKET  = 2'd2;

    localparam logic [7:0] CPU_PORT_RESET = 8'd254;

    localparam int BYTES_FIELD_MAX = 8191;
    localparam int MAX_CELLS       = 64;
    localparam int RULE_INDEX_SPAN = 32;
    localparam int FLOW_INDEX_SPAN = 16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  entry_index;
        logic        entry_valid;
        logic [7:0]  source_id;
        logic [7:0]  dest_id;
        logic [2:0]  priority_req;
        logic [3:0]  target_flow;
        logic [3:0]  target_queue;
        logic [7:0]  target_port;
        logic [12:0] packet_bytes;
    } in_item_t;

    typedef struct packed {
        logic        to_cpu;
        logic        start_mark;
        logic        end_mark;
        logic [5:0]  cell_seq;
        logic [12:0] valid_bytes;
        logic [3:0]  queue_out;
        logic [7:0]  port_out;
        logic [3:0]  flow_out;
        logic [7:0]  src_out;
        logic [7:0]  dst_out;
        logic [2:0]  pri_out;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic match;
        logic pick;
        logic load;
        logic first;
    } dp_cmd_t;

    typedef struct packed {
        logic pkt_go;
        logic last;
    } dp_status_t;

endpackage

// ===== rtl/flp_ctrl.sv =====
// ----------------------------------------------------------------------------
// flp_ctrl: sequencing controller
// Steps one input transaction through compare, select, cell load and
// delivery of its result transactions.
// ----------------------------------------------------------------------------
module flp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  flp_pkg::dp_status_t status,
    output flp_pkg::dp_cmd_t   cmd
);
    import flp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MATCH = 5'b00010,
        ST_PICK  = 5'b00100,
        ST_LOAD  = 5'b01000,
        ST_SEND  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_SEND);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.take = s_valid;
                if (s_valid && status.pkt_go) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.match  = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK: begin
                cmd.pick   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                cmd.first  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/flp_datapath.sv =====
// ----------------------------------------------------------------------------
// flp_datapath: tables, key match and cell segmentation
// Holds the rule entries and the flow memory, matches a packet key against
// all rules, and produces one registered result transaction per load.
// ----------------------------------------------------------------------------
module flp_datapath #(
    parameter int CELL_BYTES       = 64,
    parameter int RULE_ENTRIES     = 32,
    parameter int FLOW_ENTRIES     = 16,
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  flp_pkg::in_item_t   s_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  flp_pkg::dp_cmd_t    cmd,
    output flp_pkg::dp_status_t status,
    output flp_pkg::out_item_t  m_data
);
    import flp_pkg::*;

    localparam int RULE_DEPTH = (RULE_ENTRIES < RULE_INDEX_SPAN) ? RULE_ENTRIES
                                                                 : RULE_INDEX_SPAN;
    localparam int FLOW_DEPTH = (FLOW_ENTRIES < FLOW_INDEX_SPAN) ? FLOW_ENTRIES
                                                                 : FLOW_INDEX_SPAN;
    localparam int RA_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int FA_W = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
    localparam int LEN_CAP = (MAX_PACKET_BYTES < BYTES_FIELD_MAX) ? MAX_PACKET_BYTES
                                                                  : BYTES_FIELD_MAX;
    localparam int HIT_CAP = (LEN_CAP < CELL_BYTES * MAX_CELLS) ? LEN_CAP
                                                                : CELL_BYTES * MAX_CELLS;
    localparam logic [16:0] LEN_CAP_W = 17'(LEN_CAP);
    localparam logic [12:0] LEN_CAP_V = 13'(LEN_CAP);
    localparam logic [12:0] HIT_CAP_V = 13'(HIT_CAP);
    localparam logic [12:0] CELL_V    = 13'(CELL_BYTES);
    localparam logic [5:0]  RULE_LIM  = 6'(RULE_DEPTH);
    localparam logic [5:0]  FLOW_LIM  = 6'(FLOW_DEPTH);
    localparam logic [4:0]  FLOW_SEL_LIM = 5'(FLOW_DEPTH);

    logic                  rule_valid_reg [RULE_DEPTH];
    logic [18:0]           rule_key_reg   [RULE_DEPTH];
    logic [3:0]            rule_flow_reg  [RULE_DEPTH];
    logic [11:0]           flow_mem       [FLOW_DEPTH];

    logic [7:0]            cpu_port_reg;
    logic [18:0]           key_reg;
    logic [12:0]           len_reg;
    logic [RULE_DEPTH-1:0] match_reg;
    logic                  hit_reg;
    logic [3:0]            flow_reg;
    logic                  flow_ok_reg;
    logic [11:0]           flow_rd_reg;
    logic [12:0]           rest_reg;
    logic [5:0]            seq_reg;
    out_item_t             out_reg;

    logic [18:0]           in_key;
    logic [12:0]           len_sat;
    logic [RA_W-1:0]       pick_idx;
    logic                  pick_hit;
    logic [3:0]            sel_flow;
    logic                  sel_flow_ok;
    logic [12:0]           hit_len;
    logic [12:0]           rest_src;
    logic [5:0]            seq_src;
    logic                  big;
    out_item_t             out_next;

    assign in_key  = {s_data.source_id, s_data.dest_id, s_data.priority_req};
    assign len_sat = ({4'b0, s_data.packet_bytes} > LEN_CAP_W) ? LEN_CAP_V
                                                               : s_data.packet_bytes;

    assign status.pkt_go = (s_data.opcode == OP_PACKET) && (s_data.packet_bytes != 13'd0);
    assign status.last   = out_reg.end_mark;
    assign m_data        = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_port_reg <= CPU_PORT_RESET;
        end else if (cfg_we) begin
            cpu_port_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < RULE_DEPTH; i++) begin
            if (!aresetn) begin
                rule_valid_reg[i] <= 1'b0;
            end else if (cmd.take && (s_data.opcode == OP_RULE_WR)
                         && ({1'b0, s_data.entry_index} < RULE_LIM)
                         && (s_data.entry_index[RA_W-1:0] == RA_W'(i))) begin
                rule_valid_reg[i] <= s_data.entry_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < RULE_DEPTH; i++) begin
            if (cmd.take && (s_data.opcode == OP_RULE_WR)
                && ({1'b0, s_data.entry_index} < RULE_LIM)
                && (s_data.entry_index[RA_W-1:0] == RA_W'(i))) begin
                rule_key_reg[i]  <= in_key;
                rule_flow_reg[i] <= s_data.target_flow;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && (s_data.opcode == OP_FLOW_WR)
            && ({1'b0, s_data.entry_index} < FLOW_LIM)) begin
            flow_mem[s_data.entry_index[FA_W-1:0]] <= {s_data.target_queue,
                                                       s_data.target_port};
        end
        if (cmd.pick) begin
            flow_rd_reg <= flow_mem[sel_flow[FA_W-1:0]];
        end
    end

    always_comb begin
        pick_idx = '0;
        pick_hit = 1'b0;
        for (int i = RULE_DEPTH - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                pick_idx = RA_W'(i);
                pick_hit = 1'b1;
            end
        end
    end

    assign sel_flow    = rule_flow_reg[pick_idx];
    assign sel_flow_ok = ({1'b0, sel_flow} < FLOW_SEL_LIM);

    assign hit_len  = (len_reg > HIT_CAP_V) ? HIT_CAP_V : len_reg;
    assign rest_src = cmd.first ? (hit_reg ? hit_len : len_reg) : rest_reg;
    assign seq_src  = cmd.first ? 6'd0 : seq_reg;
    assign big      = hit_reg && (rest_src > CELL_V);

    always_comb begin
        out_next.to_cpu      = !hit_reg;
        out_next.start_mark  = (seq_src == 6'd0);
        out_next.end_mark    = !big;
        out_next.cell_seq    = seq_src;
        out_next.valid_bytes = big ? CELL_V : rest_src;
        out_next.queue_out   = (hit_reg && flow_ok_reg) ? flow_rd_reg[11:8] : 4'd0;
        out_next.port_out    = hit_reg ? (flow_ok_reg ? flow_rd_reg[7:0] : 8'd0)
                                       : cpu_port_reg;
        out_next.flow_out    = hit_reg ? flow_reg : 4'd0;
        out_next.src_out     = key_reg[18:11];
        out_next.dst_out     = key_reg[10:3];
        out_next.pri_out     = key_reg[2:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            key_reg <= in_key;
            len_reg <= len_sat;
        end
        if (cmd.match) begin
            for (int i = 0; i < RULE_DEPTH; i++) begin
                match_reg[i] <= rule_valid_reg[i] && (rule_key_reg[i] == key_reg);
            end
        end
        if (cmd.pick) begin
            hit_reg     <= pick_hit;
            flow_reg    <= sel_flow;
            flow_ok_reg <= sel_flow_ok;
        end
        if (cmd.load) begin
            out_reg  <= out_next;
            rest_reg <= rest_src - CELL_V;
            seq_reg  <= seq_src + 6'd1;
        end
    end

endmodule

// ===== rtl/flow_lookup_packet_to_cell.sv =====
// ----------------------------------------------------------------------------
// flow_lookup_packet_to_cell: exact-match flow lookup and cell segmenter
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// The block handles one input transaction at a time. A rule write, a flow
// write, an unused opcode or a zero-length packet is taken while the
// controller stays idle, so the input stays ready. A packet passes these
// steps in order before its first result is shown: acceptance, the parallel
// key compare against all rules, the lowest-match select with the flow
// memory read, and the load of the first cell into the output register.
// After that, one result is delivered per cycle while m_ready is high; a
// packet that misses gives a single result to the CPU port. This behaviour
// follows from the single output register and the controller sequence.
module flow_lookup_packet_to_cell #(
    parameter int CELL_BYTES       = 64,
    parameter int RULE_ENTRIES     = 32,
    parameter int FLOW_ENTRIES     = 16,
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  flp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output flp_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);
    import flp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    flp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    flp_datapath #(
        .CELL_BYTES       (CELL_BYTES),
        .RULE_ENTRIES     (RULE_ENTRIES),
        .FLOW_ENTRIES     (FLOW_ENTRIES),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

// ===== tb/sv/flow_lookup_packet_to_cell_test.sv =====
// ----------------------------------------------------------------------------
// flow_lookup_packet_to_cell_test: self-checking bench for the cell segmenter
// Directed tests cover CPU misses, flow and rule table writes, lowest-match
// selection, length saturation and the CPU port register; a backpressure
// test and three random phases follow. A local predictor queues expected cells.
// ----------------------------------------------------------------------------
module flow_lookup_packet_to_cell_test;

    timeunit 1ns;
    timeprecision 1ps;

    import flp_pkg::*;

    localparam int CELL_BYTES       = 64;
    localparam int RULE_ENTRIES     = 32;
    localparam int FLOW_ENTRIES     = 16;
    localparam int MAX_PACKET_BYTES = 4096;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    // Predictor state.
    logic       rule_on   [RULE_ENTRIES] = '{default: 1'b0};
    logic [7:0] rule_src  [RULE_ENTRIES] = '{default: '0};
    logic [7:0] rule_dst  [RULE_ENTRIES] = '{default: '0};
    logic [2:0] rule_pri  [RULE_ENTRIES] = '{default: '0};
    logic [3:0] rule_flow [RULE_ENTRIES] = '{default: '0};
    logic [3:0] flow_queue [FLOW_ENTRIES] = '{default: '0};
    logic [7:0] flow_port  [FLOW_ENTRIES] = '{default: '0};
    logic [7:0] cpu_port_model = CPU_PORT_RESET;

    out_item_t pending_cells[$];
    int        mismatch_count = 0;
    bit        idling = 1'b1;
    int        stall_request = 0;
    int        stall_left = 0;

    flow_lookup_packet_to_cell #(
        .CELL_BYTES      (CELL_BYTES),
        .RULE_ENTRIES    (RULE_ENTRIES),
        .FLOW_ENTRIES    (FLOW_ENTRIES),
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic string describe(input out_item_t r);
        return {$sformatf("cpu=%0d sop=%0d eop=%0d seq=%0d bytes=%0d ",
                          r.to_cpu, r.start_mark, r.end_mark, r.cell_seq,
                          r.valid_bytes),
                $sformatf("q=%0d port=%0d flow=%0d key=%0d/%0d/%0d",
                          r.queue_out, r.port_out, r.flow_out, r.src_out,
                          r.dst_out, r.pri_out)};
    endfunction

    function automatic bit fields_match(input out_item_t a, input out_item_t b);
        return a.to_cpu === b.to_cpu && a.start_mark === b.start_mark &&
               a.end_mark === b.end_mark && a.cell_seq === b.cell_seq &&
               a.valid_bytes === b.valid_bytes && a.queue_out === b.queue_out &&
               a.port_out === b.port_out && a.flow_out === b.flow_out &&
               a.src_out === b.src_out && a.dst_out === b.dst_out &&
               a.pri_out === b.pri_out;
    endfunction

    task automatic predict_lookup_and_cells(input in_item_t it);
        int         len;
        int         rest;
        int         k;
        bit         found;
        logic [4:0] hit_idx;
        logic [3:0] flow_idx;
        out_item_t  r;
        case (it.opcode)
            OP_RULE_WR: begin
                if (it.entry_index < RULE_ENTRIES) begin
                    rule_on[it.entry_index]   = it.entry_valid;
                    rule_src[it.entry_index]  = it.source_id;
                    rule_dst[it.entry_index]  = it.dest_id;
                    rule_pri[it.entry_index]  = it.priority_req;
                    rule_flow[it.entry_index] = it.target_flow;
                end
            end
            OP_FLOW_WR: begin
                if (it.entry_index < FLOW_ENTRIES) begin
                    flow_queue[it.entry_index[3:0]] = it.target_queue;
                    flow_port[it.entry_index[3:0]]  = it.target_port;
                end
            end
            OP_PACKET: begin
                len = it.packet_bytes;
                if (len > MAX_PACKET_BYTES) len = MAX_PACKET_BYTES;
                if (len > BYTES_FIELD_MAX) len = BYTES_FIELD_MAX;
                if (len != 0) begin
                    found   = 1'b0;
                    hit_idx = '0;
                    for (int i = 0; i < RULE_ENTRIES; i++) begin
                        if (!found && rule_on[i] && rule_src[i] == it.source_id &&
                            rule_dst[i] == it.dest_id && rule_pri[i] == it.priority_req) begin
                            found   = 1'b1;
                            hit_idx = 5'(i);
                        end
                    end
                    r = '0;
                    r.src_out = it.source_id;
                    r.dst_out = it.dest_id;
                    r.pri_out = it.priority_req;
                    if (!found) begin
                        r.to_cpu      = 1'b1;
                        r.start_mark  = 1'b1;
                        r.end_mark    = 1'b1;
                        r.valid_bytes = 13'(len);
                        r.port_out    = cpu_port_model;
                        pending_cells = {pending_cells, r};
                    end else begin
                        flow_idx   = rule_flow[hit_idx];
                        r.flow_out = flow_idx;
                        if (flow_idx < FLOW_ENTRIES) begin
                            r.queue_out = flow_queue[flow_idx];
                            r.port_out  = flow_port[flow_idx];
                        end
                        if (len > MAX_CELLS * CELL_BYTES) len = MAX_CELLS * CELL_BYTES;
                        rest = len;
                        k = 0;
                        while (rest > CELL_BYTES) begin
                            r.start_mark  = (k == 0);
                            r.end_mark    = 1'b0;
                            r.cell_seq    = 6'(k);
                            r.valid_bytes = 13'(CELL_BYTES);
                            pending_cells = {pending_cells, r};
                            rest -= CELL_BYTES;
                            k++;
                        end
                        r.start_mark  = (k == 0);
                        r.end_mark    = 1'b1;
                        r.cell_seq    = 6'(k);
                        r.valid_bytes = 13'(rest);
                        pending_cells = {pending_cells, r};
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected transaction: %s", describe(got));
        end else begin
            want = pending_cells[0];
            pending_cells.delete(0);
            if (!fields_match(got, want)) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Mismatch: expected %s", describe(want));
                    $display("          actual   %s", describe(got));
                end
            end
        end
    endtask

    // Result side: checks each transaction and drives m_ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result(m_data);
        if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(99) < 32) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic in_item_t random_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    task automatic send_item(input in_item_t it);
        while (idling && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_lookup_and_cells(it);
    endtask

    task automatic send_rule(input logic [4:0] index, input logic valid, input logic [7:0] src,
                             input logic [7:0] dst, input logic [2:0] pri,
                             input logic [3:0] flow);
        in_item_t it;
        it = random_fields();
        it.opcode       = OP_RULE_WR;
        it.entry_index  = index;
        it.entry_valid  = valid;
        it.source_id    = src;
        it.dest_id      = dst;
        it.priority_req = pri;
        it.target_flow  = flow;
        send_item(it);
    endtask

    task automatic send_flow(input logic [4:0] index, input logic [3:0] queue,
                             input logic [7:0] port);
        in_item_t it;
        it = random_fields();
        it.opcode       = OP_FLOW_WR;
        it.entry_index  = index;
        it.target_queue = queue;
        it.target_port  = port;
        send_item(it);
    endtask

    task automatic send_packet(input logic [7:0] src, input logic [7:0] dst,
                               input logic [2:0] pri, input logic [12:0] bytes);
        in_item_t it;
        it = random_fields();
        it.opcode       = OP_PACKET;
        it.source_id    = src;
        it.dest_id      = dst;
        it.priority_req = pri;
        it.packet_bytes = bytes;
        send_item(it);
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_cells.size() != 0 && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_cpu_port(input logic [7:0] value);
        wait_for_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cpu_port_model = value;
    endtask

    task automatic test_misses_after_reset();
        in_item_t it;
        send_packet(8'd1, 8'd2, 3'd3, 13'd1);
        send_packet(8'd1, 8'd2, 3'd3, 13'd0);
        it = random_fields();
        it.opcode = OP_UNUSED;
        send_item(it);
        send_packet(8'd255, 8'd0, 3'd7, 13'd8191);
        wait_for_results();
    endtask

    task automatic test_flow_table_writes();
        for (int i = 0; i < FLOW_ENTRIES; i++) begin
            if (i == 0) send_flow(5'(i), 4'd0, 8'd0);
            else if (i == FLOW_ENTRIES - 1) send_flow(5'(i), 4'd15, 8'd255);
            else send_flow(5'(i), 4'($urandom_range(15)), 8'($urandom_range(255)));
        end
        // Writes above the flow table must leave it unchanged.
        send_flow(5'd16, 4'd9, 8'd77);
        send_flow(5'd31, 4'd6, 8'd88);
    endtask

    task automatic test_segmentation();
        send_rule(5'd0, 1'b1, 8'd255, 8'd255, 3'd7, 4'd15);
        send_rule(5'd1, 1'b1, 8'd0, 8'd0, 3'd0, 4'd0);
        send_packet(8'd255, 8'd255, 3'd7, 13'd64);
        send_packet(8'd255, 8'd255, 3'd7, 13'd65);
        send_packet(8'd255, 8'd255, 3'd7, 13'd4096);
        send_packet(8'd255, 8'd255, 3'd7, 13'd8191);
        send_packet(8'd0, 8'd0, 3'd0, 13'd1);
        send_packet(8'd0, 8'd0, 3'd0, 13'd63);
        send_packet(8'd0, 8'd0, 3'd0, 13'd128);
        send_packet(8'd0, 8'd0, 3'd0, 13'd4097);
        wait_for_results();
    endtask

    task automatic test_lowest_match();
        send_rule(5'd5, 1'b1, 8'd12, 8'd34, 3'd3, 4'd2);
        send_rule(5'd9, 1'b1, 8'd12, 8'd34, 3'd3, 4'd7);
        send_packet(8'd12, 8'd34, 3'd3, 13'd100);
        send_rule(5'd5, 1'b0, 8'd12, 8'd34, 3'd3, 4'd2);
        send_packet(8'd12, 8'd34, 3'd3, 13'd100);
        send_rule(5'd31, 1'b1, 8'd200, 8'd100, 3'd5, 4'd9);
        send_packet(8'd200, 8'd100, 3'd5, 13'd30);
        send_rule(5'd31, 1'b0, 8'd200, 8'd100, 3'd5, 4'd9);
        send_packet(8'd200, 8'd100, 3'd5, 13'd30);
        wait_for_results();
    endtask

    task automatic test_cpu_port_register();
        write_cpu_port(8'd0);
        send_packet(8'd77, 8'd66, 3'd1, 13'd500);
        write_cpu_port(8'd255);
        send_packet(8'd78, 8'd66, 3'd2, 13'd4096);
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        stall_request = 400;
        for (int i = 0; i < 8; i++) send_packet(8'd0, 8'd0, 3'd0, 13'd200);
        send_packet(8'd12, 8'd34, 3'd3, 13'd150);
        wait_for_results();
    endtask

    task automatic send_random_item();
        in_item_t   it;
        int         pick;
        logic [4:0] j;
        int         lp;
        it = random_fields();
        pick = $urandom_range(99);
        j = 5'($urandom_range(RULE_ENTRIES - 1));
        if (pick < 14) begin
            it.opcode = OP_RULE_WR;
            it.entry_valid = ($urandom_range(9) < 8);
            if ($urandom_range(2) == 0) begin
                it.source_id    = rule_src[j];
                it.dest_id      = rule_dst[j];
                it.priority_req = rule_pri[j];
            end
        end else if (pick < 20) begin
            it.opcode = OP_FLOW_WR;
        end else if (pick < 24) begin
            it.opcode = OP_UNUSED;
        end else begin
            it.opcode = OP_PACKET;
            if ($urandom_range(9) < 7 && rule_on[j]) begin
                it.source_id    = rule_src[j];
                it.dest_id      = rule_dst[j];
                it.priority_req = rule_pri[j];
            end
            lp = $urandom_range(99);
            if (lp < 4) it.packet_bytes = 13'd0;
            else if (lp < 7) it.packet_bytes = 13'($urandom_range(8191, 4000));
            else if (lp < 20) it.packet_bytes =
                13'(CELL_BYTES * $urandom_range(1, 4) + $urandom_range(2) - 1);
            else it.packet_bytes = 13'($urandom_range(1, 200));
        end
        send_item(it);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            idling = (phase != 0);
            for (int i = 0; i < 33; i++) send_random_item();
            write_cpu_port(8'($urandom_range(255)));
        end
        idling = 1'b1;
        wait_for_results();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_misses_after_reset();
        test_flow_table_writes();
        test_segmentation();
        test_lowest_match();
        test_cpu_port_register();
        test_output_backpressure();
        test_random_traffic();
        repeat (10) @(posedge aclk);
        mismatch_count += pending_cells.size();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
